FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/grle_pkg.sv
package grle_pkg;

    localparam int COUNT_BITS = 16;

    // Decimal path is wide enough for the five-digit limit.
    localparam int DEC_W     = 17;
    localparam int DIGIT_MAX = 99999;
    localparam int CNT_W     = (COUNT_BITS < DEC_W) ? COUNT_BITS : DEC_W;

    localparam logic [CNT_W-1:0] COUNT_CAP = (COUNT_BITS < DEC_W) ?
        CNT_W'((64'd1 << COUNT_BITS) - 64'd1) : CNT_W'(DIGIT_MAX);

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] HEADER_MARK  = 8'd62;
    localparam logic [7:0] DEFAULT_GAP  = 8'd45;
    localparam logic [7:0] ASCII_ZERO   = 8'd48;

    // Position of a decimal digit, 0 is the units digit.
    localparam int POS_W = 3;

    typedef struct packed {
        logic [CNT_W-1:0] count;   // pending gap count to print, zero for none
        logic [7:0]       data;    // byte that closes the request
    } job_t;

    function automatic logic [DEC_W-1:0] pow10(input logic [POS_W-1:0] pos);
        logic [DEC_W-1:0] p;
        case (pos)
            3'd0:    p = DEC_W'(1);
            3'd1:    p = DEC_W'(10);
            3'd2:    p = DEC_W'(100);
            3'd3:    p = DEC_W'(1000);
            3'd4:    p = DEC_W'(10000);
            default: p = DEC_W'(1);
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/core/grle_classify.sv
module grle_classify (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    output logic              job_valid,
    output grle_pkg::job_t    job
);
    import grle_pkg::*;

    logic [7:0]       gap_char_reg;
    logic [CNT_W-1:0] run_count_reg;
    logic             in_header_reg;
    logic             at_line_start_reg;

    logic is_nl;
    logic hdr_start;
    logic is_gap;
    logic flush;

    always_comb begin
        is_nl     = (in_byte == NEWLINE_BYTE);
        hdr_start = !is_nl && at_line_start_reg && (in_byte == HEADER_MARK);
        is_gap    = !is_nl && !hdr_start && !in_header_reg && (in_byte == gap_char_reg);
        flush     = !in_header_reg && !hdr_start && !is_gap;
        job_valid = !is_gap;
        job.count = flush ? run_count_reg : '0;
        job.data  = in_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_char_reg      <= DEFAULT_GAP;
            run_count_reg     <= '0;
            in_header_reg     <= 1'b0;
            at_line_start_reg <= 1'b1;
        end else begin
            if (cfg_we) begin
                gap_char_reg <= cfg_wdata;
            end
            if (accept) begin
                if (is_nl) begin
                    in_header_reg     <= 1'b0;
                    at_line_start_reg <= 1'b1;
                end else begin
                    at_line_start_reg <= 1'b0;
                    if (hdr_start) begin
                        in_header_reg <= 1'b1;
                    end
                end
                // Clear on flush, saturate while counting.
                if (flush) begin
                    run_count_reg <= '0;
                end else if (is_gap && (run_count_reg < COUNT_CAP)) begin
                    run_count_reg <= run_count_reg + CNT_W'(1);
                end
            end
        end
    end

endmodule

FILE: rtl/core/grle_emit.sv
module grle_emit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_in_valid,
    input  grle_pkg::job_t    job_in,
    output logic              job_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] out_byte
    output logic              m_tlast
);
    import grle_pkg::*;

    logic             job_valid_reg;
    logic             job_dig_reg;
    logic [CNT_W-1:0] job_rem_reg;
    logic [POS_W-1:0] job_pos_reg;
    logic [7:0]       job_byte_reg;

    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic             m_last_reg;

    logic             out_load;
    logic             take_byte;
    logic [DEC_W-1:0] rem_ext;
    logic [DEC_W-1:0] p10;
    logic [DEC_W-1:0] sub;
    logic [3:0]       digit;
    logic [DEC_W-1:0] cnt_ext;
    logic [POS_W-1:0] load_pos;

    always_comb begin
        out_load  = !m_valid_reg || m_tready;
        take_byte = job_valid_reg && !job_dig_reg && out_load;
        job_ready = !job_valid_reg || take_byte;

        // Leading digit by parallel compares against the multiples of the power.
        rem_ext = DEC_W'(job_rem_reg);
        p10     = pow10(job_pos_reg);
        digit   = 4'd0;
        sub     = '0;
        for (int k = 1; k <= 9; k++) begin
            if (rem_ext >= DEC_W'(k) * p10) begin
                digit = 4'(k);
                sub   = DEC_W'(k) * p10;
            end
        end

        cnt_ext = DEC_W'(job_in.count);
        if (cnt_ext >= DEC_W'(10000)) begin
            load_pos = 3'd4;
        end else if (cnt_ext >= DEC_W'(1000)) begin
            load_pos = 3'd3;
        end else if (cnt_ext >= DEC_W'(100)) begin
            load_pos = 3'd2;
        end else if (cnt_ext >= DEC_W'(10)) begin
            load_pos = 3'd1;
        end else begin
            load_pos = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= job_valid_reg;
                if (job_valid_reg && job_dig_reg) begin
                    m_data_reg  <= ASCII_ZERO + {4'd0, digit};
                    m_last_reg  <= 1'b0;
                    job_rem_reg <= CNT_W'(rem_ext - sub);
                    if (job_pos_reg == '0) begin
                        job_dig_reg <= 1'b0;
                    end else begin
                        job_pos_reg <= job_pos_reg - POS_W'(1);
                    end
                end else begin
                    m_data_reg <= job_byte_reg;
                    m_last_reg <= 1'b1;
                end
            end
            // Load the next request once the current one has sent its byte.
            if (job_in_valid && job_ready) begin
                job_valid_reg <= 1'b1;
                job_rem_reg   <= job_in.count;
                job_pos_reg   <= load_pos;
                job_dig_reg   <= (job_in.count != '0);
                job_byte_reg  <= job_in.data;
            end else if (take_byte) begin
                job_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: rtl/core/gap_run_length_encoder.sv
// A request's first result goes through the request registers, then the output register, to m_tdata.
// Throughput: one byte per cycle while no gap count is printing and m_tready is high;
// a byte that flushes a gap count of d digits is sent after those d digits and holds
// s_tready low while the digit unit walks the count one decimal place per cycle, as m_tready allows.
// Reset (aresetn low, synchronous): gap_char back to '-', count zero, line start,
// request and output registers empty.
`include "assert_macros.svh"

module gap_run_length_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tlast
);
    import grle_pkg::*;

    logic  accept;
    logic  job_valid;
    job_t  job;
    logic  job_ready;

    assign s_tready = job_ready;
    assign accept   = s_tvalid && job_ready;

    grle_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_byte   (s_tdata),
        .job_valid (job_valid),
        .job       (job)
    );

    grle_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_in_valid (s_tvalid && job_valid),
        .job_in       (job),
        .job_ready    (job_ready),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    // A result that is not the last of its request is an ASCII digit.
    `ASSERT_IMPL(a_digit_ascii, aclk, aresetn, m_tvalid && !m_tlast, (m_tdata >= 8'd48) && (m_tdata <= 8'd57))
    // A digit is always followed by another result right away.
    `ASSERT_NEXT(a_digit_follow, aclk, aresetn, m_tvalid && !m_tlast, m_tvalid)

endmodule
